// ===== rtl/iirdf_pkg.sv =====
// Shared constants, control-word types and microcode ROM of the direct form I IIR filter.
package iirdf_pkg;

  localparam int Order     = 3;    // filter order, 1..3
  localparam int HistDepth = 3;
  localparam int HistIdxW  = $clog2(HistDepth);
  localparam int SampleW   = 16;
  localparam int CoefW     = 16;
  localparam int NumRegs   = 8;
  localparam int RegIdxW   = $clog2(NumRegs);
  localparam int AccW      = 34;   // seven Q3.29 products, exact
  localparam int MulAW     = AccW;
  localparam int ProdW     = MulAW + CoefW;
  localparam int RoundShift = 28;
  localparam int YWideW    = ProdW - RoundShift;
  localparam int StepW     = 4;

  localparam logic [StepW-1:0] StepIdle  = StepW'(0);
  localparam logic [StepW-1:0] StepFirst = StepW'(1);
  localparam logic [StepW-1:0] StepDrain = StepW'(7);

  localparam logic [RegIdxW-1:0] RegA0 = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegA1 = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegA2 = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegA3 = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegB1 = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] RegB2 = RegIdxW'(5);
  localparam logic [RegIdxW-1:0] RegB3 = RegIdxW'(6);
  localparam logic [RegIdxW-1:0] RegRecip = RegIdxW'(7);

  localparam logic [CoefW-1:0] CoefOne = CoefW'(16384);

  typedef logic [NumRegs-1:0][CoefW-1:0] coef_arr_t;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_XHIST,
    SRC_YHIST,
    SRC_ACC
  } src_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,      // wait for an item, start on accept
    SEQ_NEXT,
    SEQ_SKIP_LT2,  // jump to target when order is below 2
    SEQ_SKIP_LT3,  // jump to target when order is below 3
    SEQ_FINAL      // deliver result, may take the next item
  } seq_op_e;

  typedef struct packed {
    logic [RegIdxW-1:0]  coef_sel;
    src_sel_e            src_sel;
    logic [HistIdxW-1:0] hist_idx;
    logic                mul_en;
    acc_op_e             acc_op;
    seq_op_e             seq_op;
    logic [StepW-1:0]    target;
  } ucode_t;

  typedef struct packed {
    logic [RegIdxW-1:0]  coef_sel;
    src_sel_e            src_sel;
    logic [HistIdxW-1:0] hist_idx;
    logic                prod_en;
    acc_op_e             acc_op;
    logic                accept;
    logic                finish;
  } dp_ctrl_t;

  // Accumulator op of each step acts on the product registered by the step before.
  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t w;
    w = '{RegA0, SRC_IN, HistIdxW'(0), 1'b1, ACC_HOLD, SEQ_IDLE, StepIdle};
    unique case (step)
      StepW'(0): w = '{RegA0, SRC_IN, HistIdxW'(0), 1'b1, ACC_HOLD, SEQ_IDLE, StepIdle};
      StepW'(1): w = '{RegA1, SRC_XHIST, HistIdxW'(0), 1'b1, ACC_LOAD, SEQ_NEXT, StepIdle};
      StepW'(2): w = '{RegB1, SRC_YHIST, HistIdxW'(0), 1'b1, ACC_ADD, SEQ_SKIP_LT2, StepDrain};
      StepW'(3): w = '{RegA2, SRC_XHIST, HistIdxW'(1), 1'b1, ACC_SUB, SEQ_NEXT, StepIdle};
      StepW'(4): w = '{RegB2, SRC_YHIST, HistIdxW'(1), 1'b1, ACC_ADD, SEQ_SKIP_LT3, StepDrain};
      StepW'(5): w = '{RegA3, SRC_XHIST, HistIdxW'(2), 1'b1, ACC_SUB, SEQ_NEXT, StepIdle};
      StepW'(6): w = '{RegB3, SRC_YHIST, HistIdxW'(2), 1'b1, ACC_ADD, SEQ_NEXT, StepIdle};
      StepW'(7): w = '{RegA0, SRC_IN, HistIdxW'(0), 1'b0, ACC_SUB, SEQ_NEXT, StepIdle};
      StepW'(8): w = '{RegRecip, SRC_ACC, HistIdxW'(0), 1'b1, ACC_HOLD, SEQ_NEXT, StepIdle};
      StepW'(9): w = '{RegA0, SRC_IN, HistIdxW'(0), 1'b1, ACC_HOLD, SEQ_FINAL, StepIdle};
      default:   w = '{RegA0, SRC_IN, HistIdxW'(0), 1'b1, ACC_HOLD, SEQ_IDLE, StepIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/iir_filter_direct_form_top.sv =====
// Top level of the direct form I IIR filter of order up to three.
// The single shared multiplier does at most one product per microcode step, none in the
//   drain step, so the step program length sets the rate while the output is not stalled.
// The next item is taken in the last step while the output register is free.
// Reset (async, active low): both histories cleared to zero, a0 and reciprocal set to 1.0.
module iir_filter_direct_form_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [iirdf_pkg::RegIdxW-1:0]        cfg_index_i,
  input  logic [iirdf_pkg::CoefW-1:0]          cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [iirdf_pkg::SampleW-1:0] sample_in_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [iirdf_pkg::SampleW-1:0] sample_out_o,
  output logic                                 clipped_o
);
  import iirdf_pkg::*;

  coef_arr_t coefs;
  dp_ctrl_t  ctrl;

  // coefficient store; the user writes it only while idle, the block does not enforce this
  iirdf_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coefs_o     (coefs)
  );

  // microcode: a0*x on accept, then the remaining taps, a drain step for the last
  // feedback product, the scale by the reciprocal, and the round/saturate step
  iirdf_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // 34x16 multiplier with registered product feeding the accumulator
  iirdf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .coefs_i      (coefs),
    .sample_in_i  (sample_in_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

// ===== rtl/iirdf_coef_regs.sv =====
// Coefficient and reciprocal register file with a plain write port.
module iirdf_coef_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iirdf_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [iirdf_pkg::CoefW-1:0]   cfg_data_i,
  output iirdf_pkg::coef_arr_t          coefs_o
);
  import iirdf_pkg::*;

  // a0 and reciprocal start at 1.0, all other taps at zero
  function automatic coef_arr_t reset_values();
    coef_arr_t c;
    c           = '0;
    c[RegA0]    = CoefOne;
    c[RegRecip] = CoefOne;
    return c;
  endfunction

  localparam coef_arr_t RegsReset = reset_values();

  coef_arr_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegsReset;
    end else if (cfg_we_i) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign coefs_o = regs_q;

endmodule

// ===== rtl/iirdf_sequencer.sv =====
// Step counter and microcode decode that drive the filter datapath.
module iirdf_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  output iirdf_pkg::dp_ctrl_t ctrl_o
);
  import iirdf_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  ucode_t           cw;
  logic             out_free;
  logic             in_ready;
  logic             accept;
  logic             finish;

  assign cw       = ucode_rom(step_q);
  assign out_free = !out_valid_i || !out_stall_i;
  assign finish   = (cw.seq_op == SEQ_FINAL) && out_free;
  assign in_ready = (cw.seq_op == SEQ_IDLE) || finish;
  assign accept   = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  always_comb begin
    step_d = step_q + StepW'(1);
    unique case (cw.seq_op)
      SEQ_IDLE:     step_d = accept ? StepFirst : step_q;
      SEQ_NEXT:     step_d = step_q + StepW'(1);
      SEQ_SKIP_LT2: step_d = (Order < 2) ? cw.target : step_q + StepW'(1);
      SEQ_SKIP_LT3: step_d = (Order < 3) ? cw.target : step_q + StepW'(1);
      SEQ_FINAL: begin
        if (!out_free) step_d = step_q;
        else           step_d = accept ? StepFirst : StepIdle;
      end
      default:      step_d = StepIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= StepIdle;
    else         step_q <= step_d;
  end

  always_comb begin
    ctrl_o.coef_sel = cw.coef_sel;
    ctrl_o.src_sel  = cw.src_sel;
    ctrl_o.hist_idx = cw.hist_idx;
    ctrl_o.acc_op   = cw.acc_op;
    ctrl_o.accept   = accept;
    ctrl_o.finish   = finish;
    // first product of an item is taken only with the item itself
    if (cw.seq_op == SEQ_IDLE || cw.seq_op == SEQ_FINAL) ctrl_o.prod_en = accept;
    else                                                 ctrl_o.prod_en = cw.mul_en;
  end

endmodule

// ===== rtl/iirdf_datapath.sv =====
// Shared multiplier, accumulator, histories, rounding/saturation and output register.
module iirdf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iirdf_pkg::dp_ctrl_t                 ctrl_i,
  input  iirdf_pkg::coef_arr_t                coefs_i,
  input  logic signed [iirdf_pkg::SampleW-1:0] sample_in_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [iirdf_pkg::SampleW-1:0] sample_out_o,
  output logic                                clipped_o
);
  import iirdf_pkg::*;

  localparam logic signed [ProdW-1:0]  RoundHalf = ProdW'(1) << (RoundShift - 1);
  localparam logic signed [YWideW-1:0] YMax = YWideW'(32767);
  localparam logic signed [YWideW-1:0] YMin = -YWideW'(32768);

  logic signed [SampleW-1:0] xh_q [HistDepth];
  logic signed [SampleW-1:0] yh_q [HistDepth];
  logic signed [SampleW-1:0] x_q;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [CoefW-1:0]   mul_b;
  logic signed [ProdW-1:0]   mul_p;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    prod_lo;
  logic signed [AccW-1:0]    acc_q;
  logic signed [ProdW-1:0]   rounded;
  logic signed [YWideW-1:0]  y_wide;
  logic signed [SampleW-1:0] y_sat;
  logic                      y_clip;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] sample_out_q;
  logic                      clipped_q;

  always_comb begin
    unique case (ctrl_i.src_sel)
      SRC_IN:    mul_a = MulAW'(sample_in_i);
      SRC_XHIST: mul_a = MulAW'(xh_q[ctrl_i.hist_idx]);
      SRC_YHIST: mul_a = MulAW'(yh_q[ctrl_i.hist_idx]);
      SRC_ACC:   mul_a = acc_q;
      default:   mul_a = acc_q;
    endcase
  end

  assign mul_b   = $signed(coefs_i[ctrl_i.coef_sel]);
  assign mul_p   = mul_a * mul_b;
  assign prod_lo = $signed(prod_q[AccW-1:0]);

  // round half up, then floor shift to Q1.15
  assign rounded = prod_q + RoundHalf;
  assign y_wide  = $signed(rounded[ProdW-1:RoundShift]);

  always_comb begin
    y_clip = 1'b1;
    if (y_wide > YMax)      y_sat = SampleW'(YMax);
    else if (y_wide < YMin) y_sat = SampleW'(YMin);
    else begin
      y_sat  = y_wide[SampleW-1:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) prod_q <= mul_p;
    if (ctrl_i.accept)  x_q    <= sample_in_i;
    unique case (ctrl_i.acc_op)
      ACC_HOLD: acc_q <= acc_q;
      ACC_LOAD: acc_q <= prod_lo;
      ACC_ADD:  acc_q <= acc_q + prod_lo;
      ACC_SUB:  acc_q <= acc_q - prod_lo;
      default:  acc_q <= acc_q;
    endcase
    if (ctrl_i.finish) begin
      sample_out_q <= y_sat;
      clipped_q    <= y_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < HistDepth; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.finish) begin
        out_valid_q <= 1'b1;
        xh_q[0]     <= x_q;
        yh_q[0]     <= y_sat;
        for (int i = 1; i < HistDepth; i++) begin
          xh_q[i] <= xh_q[i-1];
          yh_q[i] <= yh_q[i-1];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

// ===== dv/iir_filter_direct_form_checker.sv =====
// Checker for the IIR filter: predicts each output sample and compares it with the block.
`timescale 1ns / 1ps
module iir_filter_direct_form_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [iirdf_pkg::RegIdxW-1:0]        cfg_index_i,
  input  logic [iirdf_pkg::CoefW-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [iirdf_pkg::SampleW-1:0] sample_in_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [iirdf_pkg::SampleW-1:0] sample_out_i,
  input  logic                                 clipped_i,
  output int                                   fail_count_o,
  output int                                   predicted_o,
  output int                                   checked_o,
  output int                                   saturated_o
);
  import iirdf_pkg::*;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      clipped;
  } filtered_t;

  localparam longint RoundHalf = longint'(1) <<< (RoundShift - 1);
  localparam longint SatMax    = (longint'(1) <<< (SampleW - 1)) - 1;
  localparam longint SatMin    = -(longint'(1) <<< (SampleW - 1));

  logic signed [CoefW-1:0]   coef_q [NumRegs];
  logic signed [SampleW-1:0] x_hist [HistDepth];
  logic signed [SampleW-1:0] y_hist [HistDepth];
  filtered_t                 expected_samples [$];
  int                        mismatches = 0;

  assign fail_count_o = mismatches;

  // exact products and sum, one rounding, then saturation; clipped value feeds back
  function automatic filtered_t filter_sample(input logic signed [SampleW-1:0] x);
    longint    acc;
    longint    scaled;
    longint    rounded;
    filtered_t res;
    acc = longint'(coef_q[RegA0]) * longint'(x);
    for (int k = 1; k <= Order; k++) begin
      acc += longint'(coef_q[RegA0 + k]) * longint'(x_hist[k-1]);
      acc -= longint'(coef_q[RegB1 + k - 1]) * longint'(y_hist[k-1]);
    end
    scaled  = acc * longint'(coef_q[RegRecip]);
    rounded = (scaled + RoundHalf) >>> RoundShift;
    res.clipped = 1'b0;
    if (rounded > SatMax) begin
      rounded     = SatMax;
      res.clipped = 1'b1;
    end else if (rounded < SatMin) begin
      rounded     = SatMin;
      res.clipped = 1'b1;
    end
    res.sample = SampleW'(rounded);
    for (int k = HistDepth - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = res.sample;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) coef_q[i] = '0;
      coef_q[RegA0]    = CoefOne;
      coef_q[RegRecip] = CoefOne;
      for (int k = 0; k < HistDepth; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      expected_samples.delete();
      predicted_o <= 0;
      checked_o   <= 0;
      saturated_o <= 0;
    end else begin
      if (cfg_we_i) coef_q[cfg_index_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        expected_samples.push_back(filter_sample(sample_in_i));
        predicted_o <= predicted_o + 1;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("output sample %0d with nothing pending", sample_out_i));
        end else begin
          want = expected_samples.pop_front();
          if (sample_out_i !== want.sample)
            report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                      sample_out_i, want.sample));
          if (clipped_i !== want.clipped)
            report_mismatch($sformatf("clipped %b, predicted %b (sample %0d)",
                                      clipped_i, want.clipped, want.sample));
          if (want.clipped) saturated_o <= saturated_o + 1;
        end
        checked_o <= checked_o + 1;
      end
    end
  end

endmodule

// ===== dv/iir_filter_direct_form_top_tb.sv =====
// Testbench top: feeds the IIR filter directed and random sample streams and gives the verdict.
`timescale 1ns / 1ps
module iir_filter_direct_form_top_tb;
  import iirdf_pkg::*;

  // No acceptance on either channel for this many cycles means the block hung.
  // A correct run sees at most a drain plus a coefficient load, or one item's busy
  // steps plus a stall run, between accepts.
  localparam int WatchdogLimit = 2000;
  // Quiet time after the last result, before touching coefficients and at the end.
  localparam int DrainCycles   = 4 * (3 + 2 * Order);
  localparam int RandomSets    = 12;
  localparam int ItemsPerSet   = 32;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
  localparam logic signed [CoefW-1:0]   CoefMax   = 16'sh7FFF;
  localparam logic signed [CoefW-1:0]   CoefMin   = 16'sh8000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [RegIdxW-1:0]        cfg_index_i;
  logic [CoefW-1:0]          cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_in_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      clipped_o;

  int        fail_count;
  int        predicted;
  int        checked;
  int        saturated;
  int        send_gap_pct   = 0;
  int        recv_stall_pct = 0;
  int        idle_cycles    = 0;
  int        sets_loaded    = 0;
  coef_arr_t coefs;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  iir_filter_direct_form_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

  // Watches both channels and the config port, predicts and compares.
  iir_filter_direct_form_checker result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_i (sample_out_o),
    .clipped_i    (clipped_o),
    .fail_count_o (fail_count),
    .predicted_o  (predicted),
    .checked_o    (checked),
    .saturated_o  (saturated)
  );

  // Receiver back-pressure, redrawn every cycle from the current percentage.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: restarts on any accepted item, config writes do not count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[%0t] timeout: nothing accepted for %0d cycles", $time, WatchdogLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Writes all eight coefficient registers back to back; only called while idle.
  task automatic load_coefs(input coef_arr_t c);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= RegIdxW'(i);
      cfg_data_i  <= c[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sets_loaded++;
  endtask

  // Sender side: optional random gap, then hold the item until it is taken.
  // valid is only lowered on a gap, so it never gets two assignments in one step.
  task automatic send_sample(input logic signed [SampleW-1:0] s);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending, wait for every predicted sample to come out, then let the
  // pipeline settle so a config write cannot land on a live item.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (checked < predicted) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic signed [SampleW-1:0] x;
    int                        pick;
    int                        mode;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    sample_in_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First idle pattern for the directed part: sender sparse, receiver mostly stalls.
    send_gap_pct   = 24;
    recv_stall_pct = 75;

    // Reset coefficients are a0 = 1.0 and 1/b0 = 1.0, so the output is the input.
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    drain_results();

    // Every coefficient at the positive extreme: heavy saturation, and the
    // clipped value (not the exact one) has to feed the output history.
    for (int i = 0; i < NumRegs; i++) coefs[i] = CoefMax;
    load_coefs(coefs);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(SampleMax);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    drain_results();

    // Zero reciprocal: output is zero whatever comes in, no fault.
    for (int i = 0; i < NumRegs; i++) coefs[i] = '0;
    coefs[RegA0] = CoefOne;
    coefs[RegA1] = CoefMax;
    coefs[RegB1] = CoefMin;
    load_coefs(coefs);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(16'sd12345);
    send_sample(-16'sd7);
    drain_results();

    // Every coefficient at the negative extreme.
    for (int i = 0; i < NumRegs; i++) coefs[i] = CoefMin;
    load_coefs(coefs);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain_results();

    // Random part: a fresh coefficient set per block. Idle pattern moves from
    // sender-sparse / receiver-stalling, to the reverse, to full speed.
    for (int set = 0; set < RandomSets; set++) begin
      if (set < RandomSets / 3) begin
        send_gap_pct   = 24;
        recv_stall_pct = 75;
      end else if (set < 2 * RandomSets / 3) begin
        send_gap_pct   = 75;
        recv_stall_pct = 24;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end

      mode = $urandom_range(2);
      if (mode == 0) begin
        // full-range coefficients: mostly saturating, exercises the wide path
        for (int i = 0; i < NumRegs; i++) coefs[i] = CoefW'($urandom);
      end else begin
        // tamer filter so the feedback path produces in-range outputs too
        coefs[RegA0]    = CoefW'(int'($urandom_range(16384)) - 8192);
        coefs[RegA1]    = CoefW'(int'($urandom_range(16384)) - 8192);
        coefs[RegA2]    = CoefW'(int'($urandom_range(16384)) - 8192);
        coefs[RegA3]    = CoefW'(int'($urandom_range(16384)) - 8192);
        coefs[RegB1]    = CoefW'(int'($urandom_range(8192)) - 4096);
        coefs[RegB2]    = CoefW'(int'($urandom_range(8192)) - 4096);
        coefs[RegB3]    = CoefW'(int'($urandom_range(8192)) - 4096);
        coefs[RegRecip] = CoefW'($urandom_range(16384, 4096));
      end
      load_coefs(coefs);

      for (int n = 0; n < ItemsPerSet; n++) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          case ($urandom_range(3))
            0:       x = SampleMax;
            1:       x = SampleMin;
            2:       x = '0;
            default: x = -16'sd1;
          endcase
        end else if (pick == 1) begin
          x = SampleW'(int'($urandom_range(512)) - 256);
        end else begin
          x = SampleW'($urandom);
        end
        send_sample(x);
      end
      drain_results();
    end

    $display("Covered %0d samples over %0d coefficient sets plus the reset set; %0d saturated.",
             predicted, sets_loaded, saturated);
    $display("Idle patterns run: sender-sparse, receiver-sparse, then back to back.");
    if (fail_count == 0 && checked == predicted) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iirdf_pkg.sv
rtl/iirdf_coef_regs.sv
rtl/iirdf_sequencer.sv
rtl/iirdf_datapath.sv
rtl/iir_filter_direct_form_top.sv
dv/iir_filter_direct_form_checker.sv
dv/iir_filter_direct_form_top_tb.sv
